// ===== src/pcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpp_pkg: shared types and constants for the parallel port controller
// Item and result word layouts, mode codes, register offsets, port decode.
// ----------------------------------------------------------------------------
package pcpp_pkg;

    // Item modes
    typedef enum logic [1:0] {
        MODE_IO_WR   = 2'd0,
        MODE_IO_RD   = 2'd1,
        MODE_IRQ_SET = 2'd2,
        MODE_TICK    = 2'd3
    } t_mode;

    // Register offsets within a port
    localparam logic [1:0] OFF_DATA   = 2'd0;
    localparam logic [1:0] OFF_STATUS = 2'd1;
    localparam logic [1:0] OFF_CTRL   = 2'd2;

    // Port decode
    localparam int         NUM_PORTS   = 3;
    localparam logic [1:0] PORT_LPT0   = 2'd0;
    localparam logic [1:0] PORT_LPT1   = 2'd1;
    localparam logic [1:0] PORT_LPT2   = 2'd2;
    localparam logic [1:0] NO_PORT     = 2'd3;
    localparam logic [7:0] ADDR_HI_3XX = 8'h03;
    localparam logic [7:0] ADDR_HI_2XX = 8'h02;
    localparam logic [5:0] ADDR_MID_78 = 6'h1E;  // 0x378 / 0x278
    localparam logic [5:0] ADDR_MID_BC = 6'h2F;  // 0x3BC

    // Control register bit that enables the port interrupt
    localparam int CTRL_IRQ_EN_BIT = 4;

    // Input word
    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  status_in;
        logic [7:0]  control_in;
        logic [1:0]  irq_port;
        logic        irq_level;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic       handled;
        logic [7:0] read_data;
        logic [1:0] port_index;
        logic       data_out_valid;
        logic [7:0] data_out;
        logic       control_out_valid;
        logic [3:0] control_out;
        logic       irq_update;
        logic [2:0] irq_lines;
    } t_out_word;

    // Address decode result
    typedef struct packed {
        logic       hit;
        logic [1:0] port;
        logic [1:0] offset;
    } t_dec;

endpackage

// ===== src/pc_parallel_port_controller.sv =====
// ----------------------------------------------------------------------------
// pc_parallel_port_controller: three PC parallel ports on an I/O bus
// Input register, address decode and register file, result register.
// ----------------------------------------------------------------------------
//  Channel  Valid        Stall        Word
//  -------  -----------  -----------  -----------------------
//  input    i_in_valid   o_in_stall   i_in_data  (t_in_word)
//  output   o_out_valid  i_out_stall  o_out_data (t_out_word)
//
// One word per cycle sustained while the output is not stalled; each word passes
// through the input register and then the result register.
// The port registers are read and updated for the word in the execute register, so
// back-to-back words see each other's effects in order.
// Synchronous active-low reset clears both stage valids and all port state.
// A stall on the output holds the result and the execute word; o_in_stall
// rises only when both are full.
// ----------------------------------------------------------------------------
module pc_parallel_port_controller
    import pcpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      out_load;
    logic      fire;
    t_dec      dec;
    t_out_word result;

    // Flow control
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_load;
    assign fire       = r_s1_valid && out_load;

    pcpp_decode u_decode (
        .i_address (r_s1_word.address),
        .o_dec     (dec)
    );

    pcpp_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_s1_word),
        .i_dec    (dec),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_word <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

endmodule

// ===== src/pcpp_decode.sv =====
// ----------------------------------------------------------------------------
// pcpp_decode: I/O address decoder
// Maps 0x378, 0x278 and 0x3BC blocks to ports 0..2 and splits off the offset.
// ----------------------------------------------------------------------------
module pcpp_decode
    import pcpp_pkg::*;
(
    input  logic [15:0] i_address,
    output t_dec        o_dec
);

    logic [7:0] addr_hi;
    logic [5:0] addr_mid;

    assign addr_hi  = i_address[15:8];
    assign addr_mid = i_address[7:2];

    // Port select from address bits 15:2
    always_comb begin
        o_dec.offset = i_address[1:0];
        o_dec.hit    = 1'b1;
        if (addr_mid == ADDR_MID_78 && addr_hi == ADDR_HI_3XX) begin
            o_dec.port = PORT_LPT0;
        end else if (addr_mid == ADDR_MID_78 && addr_hi == ADDR_HI_2XX) begin
            o_dec.port = PORT_LPT1;
        end else if (addr_mid == ADDR_MID_BC && addr_hi == ADDR_HI_3XX) begin
            o_dec.port = PORT_LPT2;
        end else begin
            o_dec.port = NO_PORT;
            o_dec.hit  = 1'b0;
        end
    end

endmodule

// ===== src/pcpp_regs.sv =====
// ----------------------------------------------------------------------------
// pcpp_regs: per-port register file and access logic
// Holds data mirrors, kept control bits, IRQ enables and IRQ requests, and
// forms the result word for the item in the execute register.
// ----------------------------------------------------------------------------
module pcpp_regs
    import pcpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    input  t_dec      i_dec,
    output t_out_word o_result
);

    logic [7:0] r_data_mirror [NUM_PORTS];
    logic [1:0] r_ctl_kept    [NUM_PORTS];
    logic       r_irq_en      [NUM_PORTS];
    logic [3:0] r_irq_raised;

    logic [7:0] n_data_mirror [NUM_PORTS];
    logic [1:0] n_ctl_kept    [NUM_PORTS];
    logic       n_irq_en      [NUM_PORTS];
    logic [3:0] n_irq_raised;

    logic [7:0] sel_mirror;
    logic [1:0] sel_kept;
    logic       is_io;

    assign is_io = (i_word.mode == MODE_IO_WR) || (i_word.mode == MODE_IO_RD);

    // Per-port read mux
    always_comb begin
        case (i_dec.port)
            PORT_LPT0: begin
                sel_mirror = r_data_mirror[0];
                sel_kept   = r_ctl_kept[0];
            end
            PORT_LPT1: begin
                sel_mirror = r_data_mirror[1];
                sel_kept   = r_ctl_kept[1];
            end
            PORT_LPT2: begin
                sel_mirror = r_data_mirror[2];
                sel_kept   = r_ctl_kept[2];
            end
            default: begin
                sel_mirror = 8'h00;
                sel_kept   = 2'b00;
            end
        endcase
    end

    // Result word and next state
    always_comb begin
        o_result            = '0;
        o_result.port_index = is_io ? i_dec.port : NO_PORT;
        n_irq_raised        = r_irq_raised;
        for (int i = 0; i < NUM_PORTS; i++) begin
            n_data_mirror[i] = r_data_mirror[i];
            n_ctl_kept[i]    = r_ctl_kept[i];
            n_irq_en[i]      = r_irq_en[i];
        end

        case (i_word.mode)
            MODE_IO_WR: begin
                if (i_dec.hit && i_dec.offset == OFF_DATA) begin
                    o_result.handled        = 1'b1;
                    o_result.data_out_valid = 1'b1;
                    o_result.data_out       = i_word.write_data;
                end else if (i_dec.hit && i_dec.offset == OFF_CTRL) begin
                    o_result.handled           = 1'b1;
                    o_result.control_out_valid = 1'b1;
                    o_result.control_out       = i_word.write_data[3:0];
                end
                for (int i = 0; i < NUM_PORTS; i++) begin
                    if (i_dec.hit && i_dec.port == 2'(i)) begin
                        if (i_dec.offset == OFF_DATA) begin
                            n_data_mirror[i] = i_word.write_data;
                        end else if (i_dec.offset == OFF_CTRL) begin
                            n_ctl_kept[i] = i_word.write_data[5:4];
                            n_irq_en[i]   = i_word.write_data[CTRL_IRQ_EN_BIT];
                        end
                    end
                end
            end
            MODE_IO_RD: begin
                if (i_dec.hit) begin
                    case (i_dec.offset)
                        OFF_DATA: begin
                            o_result.handled   = 1'b1;
                            o_result.read_data = sel_mirror;
                        end
                        OFF_STATUS: begin
                            o_result.handled   = 1'b1;
                            o_result.read_data = i_word.status_in;
                        end
                        OFF_CTRL: begin
                            o_result.handled   = 1'b1;
                            o_result.read_data = i_word.control_in | {2'b00, sel_kept, 4'h0};
                        end
                        default: begin
                            o_result.handled = 1'b0;
                        end
                    endcase
                end
            end
            MODE_IRQ_SET: begin
                n_irq_raised[i_word.irq_port] = i_word.irq_level;
            end
            default: begin
                // tick: line is request AND enable, one line per port
                o_result.irq_update = 1'b1;
                for (int i = 0; i < NUM_PORTS; i++) begin
                    o_result.irq_lines[i] = r_irq_raised[i] & r_irq_en[i];
                end
            end
        endcase
    end

    // State registers, updated when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_raised <= '0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_data_mirror[i] <= '0;
                r_ctl_kept[i]    <= '0;
                r_irq_en[i]      <= 1'b0;
            end
        end else if (i_fire) begin
            r_irq_raised <= n_irq_raised;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_data_mirror[i] <= n_data_mirror[i];
                r_ctl_kept[i]    <= n_ctl_kept[i];
                r_irq_en[i]      <= n_irq_en[i];
            end
        end
    end

endmodule
